// ===== rtl/tem7_pkg.sv =====
`default_nettype none

package tem7_pkg;

	// Field widths
	localparam int PIX_W    = 8;
	localparam int MASK_W   = 7;
	localparam int COORD_W  = 12;
	localparam int GEOM_W   = 13;
	localparam int THR_W    = 8;
	// Room for a clamped dimension up to 8192 plus one
	localparam int DIM_W    = 14;

	// Window geometry
	localparam int WIN      = 7;
	localparam int LINES    = 6;
	localparam int BORDER   = 3;
	localparam int SLOT_W   = 3;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Register reset values
	localparam logic [GEOM_W-1:0] RST_WIDTH  = GEOM_W'(640);
	localparam logic [GEOM_W-1:0] RST_HEIGHT = GEOM_W'(480);
	localparam logic [THR_W-1:0]  RST_STRONG = THR_W'(32);
	localparam logic [THR_W-1:0]  RST_WEAK   = THR_W'(16);

	// Mask codes
	localparam logic [MASK_W-1:0] MASK_FLAT   = MASK_W'(0);
	localparam logic [MASK_W-1:0] MASK_WEAK   = MASK_W'(64);
	localparam logic [MASK_W-1:0] MASK_STRONG = MASK_W'(100);

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_STRONG = 2'd2,
		REG_WEAK   = 2'd3
	} reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/tem7_ram.sv =====
`default_nettype none

module tem7_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Read-first: a read and a write at the same address return the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/texture_edge_mask_7x7_unit.sv =====
`default_nettype none

// Texture / edge mask over a 7x7 luma window.
// Pixels arrive in raster order on pixel/pixel_valid/pixel_ready. Each
// transfer writes the pixel into one of six line RAMs and reads the column
// above it; when stage 1 advances the 7x7 window shifts left, the new column comes
// in, and eight neighbours at (+-3,0), (+-2,+-2), (0,+-3) are compared with
// the centre. Interior centres (three pixels in from every border) give one
// result on mask_value/centre_column/centre_row/frame_last with
// mask_valid/mask_ready; border pixels give no transfer at all.
// Throughput: one pixel per clock while the output is not stalled, bounded
// by the single port of each line RAM (one read and one write per pixel).
// The pixel transfer that completes a window (that pixel is three lines and
// three columns past the centre) passes the window stage register, then the
// result is loaded into the output register.
// Stall: the output register holds a result until taken; one more pixel can
// sit in the window stage, after which pixel_ready drops.
// Reset: counters, window and output valid clear, registers take their
// defaults. The line RAMs are not cleared; the first six lines of a frame
// fill them before any read reaches a result.
// Configuration over APB at byte addresses 0 width, 4 height, 8 strong
// threshold, 12 weak threshold; write only while the block is idle.
module texture_edge_mask_7x7_unit #(
	parameter int MAX_WIDTH  = tem7_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tem7_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [3:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// pixel stream
	input  wire logic                          pixel_valid,
	output logic                               pixel_ready,
	input  wire logic [tem7_pkg::PIX_W-1:0]    pixel,
	// mask stream
	output logic                               mask_valid,
	input  wire logic                          mask_ready,
	output logic      [tem7_pkg::MASK_W-1:0]   mask_value,
	output logic      [tem7_pkg::COORD_W-1:0]  centre_column,
	output logic      [tem7_pkg::COORD_W-1:0]  centre_row,
	output logic                               frame_last
);

	import tem7_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// ---------------- configuration registers ----------------
	logic [GEOM_W-1:0] width_q, height_q;
	logic [THR_W-1:0]  strong_q, weak_q;
	reg_idx_t          reg_sel;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			strong_q <= RST_STRONG;
			weak_q   <= RST_WEAK;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[GEOM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[GEOM_W-1:0];
				REG_STRONG: strong_q <= pwdata[THR_W-1:0];
				REG_WEAK:   weak_q   <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_STRONG: prdata = 32'(strong_q);
			REG_WEAK:   prdata = 32'(weak_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------- raster position ----------------
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [SLOT_W-1:0] slot_q;   // row mod 6: line RAM written by this row
	logic [DIM_W-1:0]  w_eff, h_eff, col_x, row_x, ccol_x, crow_x;
	logic              col_end, row_end, has_res, is_last, acc;

	assign acc   = pixel_valid && pixel_ready;
	assign w_eff = (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_q);
	assign h_eff = (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) ?
		DIM_W'(MAX_HEIGHT) : DIM_W'(height_q);
	assign col_x = DIM_W'(col_q);
	assign row_x = DIM_W'(row_q);

	assign col_end = (col_x + DIM_W'(1)) >= w_eff;
	assign row_end = (row_x + DIM_W'(1)) >= h_eff;
	// interior centre sits BORDER behind the incoming pixel in both directions
	assign has_res = (col_x >= DIM_W'(2*BORDER)) && (row_x >= DIM_W'(2*BORDER)) &&
		(col_x < w_eff) && (row_x < h_eff);
	assign is_last = ((col_x + DIM_W'(1)) == w_eff) && ((row_x + DIM_W'(1)) == h_eff);
	assign ccol_x  = col_x - DIM_W'(BORDER);
	assign crow_x  = row_x - DIM_W'(BORDER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + RW'(1);
					slot_q <= (slot_q == SLOT_W'(LINES - 1)) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- line RAMs, one per line slot ----------------
	pix_t ram_rd [LINES];

	for (genvar g = 0; g < LINES; g++) begin : g_line
		tem7_ram #(
			.DATA_W (PIX_W),
			.DEPTH  (MAX_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (acc && (slot_q == SLOT_W'(g))),
			.re    (acc),
			.addr  (col_q),
			.wdata (pixel),
			.rdata (ram_rd[g])
		);
	end

	// ---------------- stage 1: window update and classify ----------------
	logic              valid_s1, res_s1, last_s1, adv_s1;
	pix_t              pix_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [COORD_W-1:0] ccol_s1, crow_s1;

	// items with no result move on regardless of the output side
	assign adv_s1      = valid_s1 && (!res_s1 || !mask_valid || mask_ready);
	assign pixel_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel;
			slot_s1 <= slot_q;
			res_s1  <= has_res;
			last_s1 <= is_last;
			ccol_s1 <= ccol_x[COORD_W-1:0];
			crow_s1 <= crow_x[COORD_W-1:0];
		end
	end

	pix_t win_q [WIN][WIN];
	pix_t win_nx [WIN][WIN];

	// shift left; new column: oldest buffered row on top, live pixel at bottom
	always_comb begin
		logic [SLOT_W:0] sidx;
		for (int k = 0; k < WIN; k++) begin
			for (int j = 0; j < WIN - 1; j++) begin
				win_nx[k][j] = win_q[k][j+1];
			end
		end
		for (int k = 0; k < LINES; k++) begin
			sidx = {1'b0, slot_s1} + (SLOT_W+1)'(k);
			if (sidx >= (SLOT_W+1)'(LINES)) begin
				sidx = sidx - (SLOT_W+1)'(LINES);
			end
			win_nx[k][WIN-1] = ram_rd[sidx[SLOT_W-1:0]];
		end
		win_nx[WIN-1][WIN-1] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) begin
				for (int j = 0; j < WIN; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else if (adv_s1) begin
			win_q <= win_nx;
		end
	end

	// neighbour - centre > thr  <=>  neighbour > centre + thr
	pix_t              nb [8];
	logic [PIX_W:0]    lim_strong, lim_weak;
	logic              any_strong, any_weak;
	logic [MASK_W-1:0] mask_nx;

	assign nb[0] = win_nx[3][6];
	assign nb[1] = win_nx[3][0];
	assign nb[2] = win_nx[5][5];
	assign nb[3] = win_nx[1][1];
	assign nb[4] = win_nx[6][3];
	assign nb[5] = win_nx[0][3];
	assign nb[6] = win_nx[5][1];
	assign nb[7] = win_nx[1][5];

	assign lim_strong = {1'b0, win_nx[3][3]} + {1'b0, strong_q};
	assign lim_weak   = {1'b0, win_nx[3][3]} + {1'b0, weak_q};

	always_comb begin
		any_strong = 1'b0;
		any_weak   = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if ({1'b0, nb[i]} > lim_strong) begin
				any_strong = 1'b1;
			end
			if ({1'b0, nb[i]} > lim_weak) begin
				any_weak = 1'b1;
			end
		end
		mask_nx = any_strong ? MASK_STRONG : (any_weak ? MASK_WEAK : MASK_FLAT);
	end

	// ---------------- output register ----------------
	logic load_out;
	assign load_out = adv_s1 && res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_valid <= 1'b0;
		end else if (load_out) begin
			mask_valid <= 1'b1;
		end else if (mask_ready) begin
			mask_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mask_value    <= mask_nx;
			centre_column <= ccol_s1;
			centre_row    <= crow_s1;
			frame_last    <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_mask_code: assert property (@(posedge clk) disable iff (!arst_n)
		mask_valid |-> (mask_value == MASK_FLAT || mask_value == MASK_WEAK ||
			mask_value == MASK_STRONG))
		else $error("mask_value holds an unknown code");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(LINES - 1))
		else $error("line slot out of range");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(pix_s1) && $stable(slot_s1)))
		else $error("window stage item lost while stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_valid && !mask_ready) |-> !load_out)
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
